// File: src/gcd_pkg.sv
package gcd_pkg;

  localparam int CORDIC_STAGES = 24;
  localparam int XW = 34;
  localparam int SQ_ITER = 31;

  localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
  localparam logic [63:0] HALF_RAD_MUL = (PI_Q60 + 64'd180000000) / 64'd360000000;
  localparam logic signed [XW-1:0] HALF_PI_Q30 = XW'((PI_Q60 + (64'd1 << 30)) >> 31);
  localparam logic signed [XW-1:0] ONE_Q30 = XW'(64'd1 << 30);
  localparam logic signed [XW-1:0] GAIN_Q30 = XW'(652032874);
  localparam logic signed [31:0] TURN_UD = 32'sd360000000;
  localparam logic signed [31:0] HALF_TURN_UD = 32'sd180000000;
  localparam logic signed [31:0] QUARTER_TURN_UD = 32'sd90000000;
  localparam logic [24:0] DIST_MAX = 25'h1FFFFFF;

  function automatic logic signed [XW-1:0] atan_q30(input int i);
    logic signed [63:0] sum;
    logic [63:0] term;
    int e;
    sum = 0;
    if (i == 0) begin
      return XW'(((PI_Q60 >> 2) + (64'd1 << 29)) >> 30);
    end
    for (int k = 0; k < 31; k++) begin
      e = 60 - i * (2 * k + 1);
      if (e >= 0) begin
        term = (64'd1 << e) / 64'(2 * k + 1);
        if (k % 2 == 1) sum = sum - $signed(term);
        else sum = sum + $signed(term);
      end
    end
    return XW'((64'(sum) + (64'd1 << 29)) >> 30);
  endfunction

  function automatic logic signed [XW-1:0] clamp_q(input logic signed [XW-1:0] v,
                                                  input logic signed [XW-1:0] lo,
                                                  input logic signed [XW-1:0] hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

endpackage

// File: src/gcd_mulq.sv
module gcd_mulq (
  input  logic                            clk,
  input  logic                            en,
  input  logic signed [gcd_pkg::XW-1:0]   a,
  input  logic signed [gcd_pkg::XW-1:0]   b,
  output logic signed [gcd_pkg::XW-1:0]   p
);
  import gcd_pkg::*;
  logic signed [2*XW-1:0] prod_r;
  logic signed [2*XW-1:0] rnd;
  always_ff @(posedge clk) begin
    if (en) prod_r <= a * b;
  end
  assign rnd = prod_r + (2*XW)'(64'd1 << 29);
  assign p = XW'(rnd >>> 30);
endmodule

// File: src/gcd_rotate.sv
module gcd_rotate (
  input  logic                           clk,
  input  logic                           en,
  input  logic signed [gcd_pkg::XW-1:0]  z_in,
  output logic signed [gcd_pkg::XW-1:0]  cos_out,
  output logic signed [gcd_pkg::XW-1:0]  sin_out
);
  import gcd_pkg::*;
  logic signed [XW-1:0] x_r [CORDIC_STAGES+1];
  logic signed [XW-1:0] y_r [CORDIC_STAGES+1];
  logic signed [XW-1:0] z_r [CORDIC_STAGES+1];

  always_comb begin
    x_r[0] = GAIN_Q30;
    y_r[0] = '0;
    z_r[0] = z_in;
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_st
    localparam logic signed [XW-1:0] ATN = atan_q30(i);
    always_ff @(posedge clk) begin
      if (en) begin
        if (z_r[i] >= 0) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - ATN;
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + ATN;
        end
      end
    end
  end

  assign cos_out = clamp_q(x_r[CORDIC_STAGES], -ONE_Q30, ONE_Q30);
  assign sin_out = clamp_q(y_r[CORDIC_STAGES], -ONE_Q30, ONE_Q30);
endmodule

// File: src/gcd_sqrt.sv
module gcd_sqrt (
  input  logic                           clk,
  input  logic                           en,
  input  logic signed [gcd_pkg::XW-1:0]  v,
  output logic signed [gcd_pkg::XW-1:0]  r
);
  import gcd_pkg::*;
  // restoring root, one result bit per stage; n = v << 30 < 2^62
  logic [61:0] n_r [SQ_ITER+1];
  logic [31:0] q_r [SQ_ITER+1];

  always_comb begin
    n_r[0] = 62'(v[30:0]) << 30;
    q_r[0] = '0;
  end

  for (genvar i = 0; i < SQ_ITER; i++) begin : g_st
    localparam int B = SQ_ITER - 1 - i;
    logic [63:0] trial;
    assign trial = (64'(q_r[i]) << (B + 1)) + (64'd1 << (2 * B));
    always_ff @(posedge clk) begin
      if (en) begin
        if (64'(n_r[i]) >= trial) begin
          n_r[i+1] <= n_r[i] - trial[61:0];
          q_r[i+1] <= q_r[i] | (32'd1 << B);
        end else begin
          n_r[i+1] <= n_r[i];
          q_r[i+1] <= q_r[i];
        end
      end
    end
  end

  assign r = XW'(q_r[SQ_ITER]);
endmodule

// File: src/gcd_vector.sv
module gcd_vector (
  input  logic                           clk,
  input  logic                           en,
  input  logic signed [gcd_pkg::XW-1:0]  x_in,
  input  logic signed [gcd_pkg::XW-1:0]  y_in,
  output logic signed [gcd_pkg::XW-1:0]  z_out
);
  import gcd_pkg::*;
  logic signed [XW-1:0] x_r [CORDIC_STAGES+1];
  logic signed [XW-1:0] y_r [CORDIC_STAGES+1];
  logic signed [XW-1:0] z_r [CORDIC_STAGES+1];

  always_comb begin
    x_r[0] = x_in;
    y_r[0] = y_in;
    z_r[0] = '0;
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_st
    localparam logic signed [XW-1:0] ATN = atan_q30(i);
    always_ff @(posedge clk) begin
      if (en) begin
        if (y_r[i] > 0) begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + ATN;
        end else begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - ATN;
        end
      end
    end
  end

  assign z_out = clamp_q(z_r[CORDIC_STAGES], '0, HALF_PI_Q30);
endmodule

// File: src/great_circle_distance.sv
// channel | beat fields (low bit first)                                         | dir
// in      | tdata: start_lat[27:0] start_lon[28:0] end_lat[27:0] end_lon[28:0]  | in
//         | tuser: ends_present                                                  |
// out     | tdata: distance_m[24:0]                                              | out
// cfg     | cfg_data: earth_radius_m[23:0]                                       | in
// One pair per cycle while the pipe is not stalled. Pairs pass through the
// wrap, radian multiply, CORDIC rotation, products, square root, CORDIC
// vectoring and scale stages. The whole pipe advances only when the
// output register is empty or taken, so a stall loses nothing.
// Reset clears valid bits and sets the radius to 6371000.
module great_circle_distance (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [119:0] in_tdata,  // start_latitude, start_longitude, end_latitude, end_longitude
  input  logic         in_tuser,  // ends_present
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [31:0]  out_tdata, // distance_m
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [23:0]  cfg_data
);
  import gcd_pkg::*;

  // valid/flag shift depth; the output register follows it as the last stage
  localparam int LAT = 2 + 2 + CORDIC_STAGES + 5 + SQ_ITER + CORDIC_STAGES + 1;

  logic        en;
  logic [LAT-1:0] vld_r;
  logic [LAT-1:0] pres_r;
  logic [23:0] radius_r;
  logic        ovld_r;
  logic [24:0] dist_r;

  assign en = !ovld_r || out_tready;
  assign in_tready = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) radius_r <= 24'd6371000;
    else if (cfg_valid) radius_r <= cfg_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) pres_r <= {pres_r[LAT-2:0], in_tuser};
  end

  // stage 1: differences, latitudes registered
  logic signed [31:0] lat1, lon1, lat2, lon2;
  assign lat1 = 32'(signed'(in_tdata[27:0]));
  assign lon1 = 32'(signed'(in_tdata[56:28]));
  assign lat2 = 32'(signed'(in_tdata[84:57]));
  assign lon2 = 32'(signed'(in_tdata[113:85]));

  logic signed [31:0] dlat_r, dlon_r, la1_r, la2_r;
  always_ff @(posedge clk) begin
    if (en) begin
      dlat_r <= lat2 - lat1;
      dlon_r <= lon2 - lon1;
      la1_r <= lat1;
      la2_r <= lat2;
    end
  end

  // wrap into [-180e6,180e6); inputs lie within (-3*180e6, 3*180e6)
  function automatic logic signed [31:0] wrap(input logic signed [31:0] d);
    logic signed [31:0] r;
    r = d;
    if (r >= HALF_TURN_UD) r = r - TURN_UD;
    else if (r < -HALF_TURN_UD) r = r + TURN_UD;
    if (r >= HALF_TURN_UD) r = r - TURN_UD;
    else if (r < -HALF_TURN_UD) r = r + TURN_UD;
    return r;
  endfunction

  function automatic logic [31:0] absv(input logic signed [31:0] d);
    return d < 0 ? 32'(-d) : 32'(d);
  endfunction

  // stage 2: wrap, fold latitude, magnitude and sign
  logic [31:0] m_r [4];
  logic        sg_r [4];
  logic        neg1_r, neg2_r;
  always_ff @(posedge clk) begin
    logic signed [31:0] w;
    logic [31:0] m;
    if (en) begin
      w = wrap(dlat_r);
      m_r[0] <= absv(w); sg_r[0] <= w < 0;
      w = wrap(dlon_r);
      m_r[1] <= absv(w); sg_r[1] <= w < 0;
      m = absv(wrap(la1_r));
      neg1_r <= $signed(m) > QUARTER_TURN_UD;
      m_r[2] <= (($signed(m) > QUARTER_TURN_UD) ? 32'(HALF_TURN_UD) - m : m) << 1;
      sg_r[2] <= 1'b0;
      m = absv(wrap(la2_r));
      neg2_r <= $signed(m) > QUARTER_TURN_UD;
      m_r[3] <= (($signed(m) > QUARTER_TURN_UD) ? 32'(HALF_TURN_UD) - m : m) << 1;
      sg_r[3] <= 1'b0;
    end
  end

  // stages 3-4: radian multiply, rounding
  logic [63:0] rp_r [4];
  logic        sg2_r [4];
  logic signed [XW-1:0] zr_r [4];
  logic negd [2];
  logic nd1_r, nd2_r;
  always_ff @(posedge clk) begin
    logic [63:0] q;
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        rp_r[k] <= 64'(m_r[k]) * HALF_RAD_MUL;
        sg2_r[k] <= sg_r[k];
        q = (rp_r[k] + (64'd1 << 29)) >> 30;
        zr_r[k] <= sg2_r[k] ? -XW'(q) : XW'(q);
      end
      nd1_r <= neg1_r; nd2_r <= neg2_r;
    end
  end

  logic signed [XW-1:0] c_o [4];
  logic signed [XW-1:0] s_o [4];
  for (genvar k = 0; k < 4; k++) begin : g_rot
    gcd_rotate u_rot (.clk(clk), .en(en), .z_in(zr_r[k]), .cos_out(c_o[k]), .sin_out(s_o[k]));
  end

  // latitude fold flags ride alongside the CORDIC
  logic [CORDIC_STAGES:0] f1_r, f2_r;
  always_ff @(posedge clk) begin
    if (en) begin
      f1_r <= {f1_r[CORDIC_STAGES-1:0], nd1_r};
      f2_r <= {f2_r[CORDIC_STAGES-1:0], nd2_r};
    end
  end
  assign negd[0] = f1_r[CORDIC_STAGES];
  assign negd[1] = f2_r[CORDIC_STAGES];

  // product stages
  logic signed [XW-1:0] c1_r, c2_r, s1_r, s2_r;
  always_ff @(posedge clk) begin
    if (en) begin
      s1_r <= s_o[0];
      s2_r <= s_o[1];
      c1_r <= negd[0] ? -c_o[2] : c_o[2];
      c2_r <= negd[1] ? -c_o[3] : c_o[3];
    end
  end

  logic signed [XW-1:0] p11, p22, pcc;
  gcd_mulq u_m11 (.clk(clk), .en(en), .a(s1_r), .b(s1_r), .p(p11));
  gcd_mulq u_m22 (.clk(clk), .en(en), .a(s2_r), .b(s2_r), .p(p22));
  gcd_mulq u_mcc (.clk(clk), .en(en), .a(c1_r), .b(c2_r), .p(pcc));

  logic signed [XW-1:0] p11_r, p22_r, pcc_r, p11b_r;
  always_ff @(posedge clk) begin
    if (en) begin
      p11_r <= p11; p22_r <= p22; pcc_r <= pcc;
    end
  end

  logic signed [XW-1:0] p3;
  gcd_mulq u_m3 (.clk(clk), .en(en), .a(pcc_r), .b(p22_r), .p(p3));

  logic signed [XW-1:0] a_r, om_r;
  always_ff @(posedge clk) begin
    logic signed [XW-1:0] a;
    if (en) begin
      p11b_r <= p11_r;
      a = clamp_q(p11b_r + p3, '0, ONE_Q30);
      a_r <= a;
      om_r <= ONE_Q30 - a;
    end
  end

  logic signed [XW-1:0] sq_a, sq_om;
  gcd_sqrt u_sqa (.clk(clk), .en(en), .v(a_r), .r(sq_a));
  gcd_sqrt u_sqo (.clk(clk), .en(en), .v(om_r), .r(sq_om));

  logic signed [XW-1:0] zc;
  gcd_vector u_vec (.clk(clk), .en(en), .x_in(sq_om), .y_in(sq_a), .z_out(zc));

  logic [55:0] sc_r;
  always_ff @(posedge clk) begin
    if (en) sc_r <= 56'(radius_r) * 56'(zc[30:0]);
  end

  logic [55:0] dd;
  assign dd = (sc_r + (56'd1 << 28)) >> 29;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovld_r <= 1'b0;
    end else if (en) begin
      ovld_r <= vld_r[LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (!pres_r[LAT-1]) dist_r <= '0;
      else if (dd > 56'(DIST_MAX)) dist_r <= DIST_MAX;
      else dist_r <= dd[24:0];
    end
  end

  assign out_tvalid = ovld_r;
  assign out_tdata = {7'd0, dist_r};
endmodule

// File: dv/great_circle_distance_test.sv
module great_circle_distance_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STAGES = 24;
  localparam longint unsigned PI_Q60 = 64'h3243F6A8885A308D;
  localparam longint unsigned RAD_MUL = (PI_Q60 + 64'd180000000) / 64'd360000000;
  localparam longint HALF_PI = longint'((PI_Q60 + (64'd1 << 30)) >> 31);
  localparam longint ONE = 64'sd1 << 30;
  localparam longint GAIN = 652032874;
  localparam longint TURN = 360000000;
  localparam longint HALF_TURN = 180000000;
  localparam longint QUARTER_TURN = 90000000;
  localparam longint unsigned SAT = 33554431;
  localparam int DRAIN = 110;

  typedef struct {
    bit present;
    logic signed [27:0] slat;
    logic signed [28:0] slon;
    logic signed [27:0] elat;
    logic signed [28:0] elon;
  } pair_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [119:0] in_tdata = '0;
  logic in_tuser = 0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [31:0] out_tdata;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [23:0] cfg_data = '0;

  great_circle_distance u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  longint atan_tab[STAGES];
  longint unsigned radius = 6371000;
  pair_t pending[$];
  logic [24:0] distances_due[$];
  int errors = 0;
  bit calm = 0;
  bit in_fire = 0;
  bit out_fire = 0;
  int gap = 0;
  int stall = 0;
  int sent = 0;

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint wrap_turn(longint d);
    longint r;
    r = d % TURN;
    if (r < -HALF_TURN) r += TURN;
    if (r >= HALF_TURN) r -= TURN;
    return r;
  endfunction

  function automatic longint to_half_rad(longint d);
    longint unsigned m;
    longint r;
    m = d < 0 ? -d : d;
    r = longint'((m * RAD_MUL + (64'd1 << 29)) >> 30);
    return d < 0 ? -r : r;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return (a * b + (64'sd1 << 29)) >>> 30;
  endfunction

  function automatic void cordic_rotate(longint z, output longint co, output longint si);
    longint x, y, dx, dy;
    x = GAIN;
    y = 0;
    for (int i = 0; i < STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_tab[i];
      end else begin
        x += dx; y -= dy; z += atan_tab[i];
      end
    end
    co = clip(x, -ONE, ONE);
    si = clip(y, -ONE, ONE);
  endfunction

  function automatic longint cordic_angle(longint x, longint y);
    longint z, dx, dy;
    z = 0;
    for (int i = 0; i < STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; z += atan_tab[i];
      end else begin
        x -= dx; y += dy; z -= atan_tab[i];
      end
    end
    return clip(z, 0, HALF_PI);
  endfunction

  function automatic longint root_q30(longint v);
    longint unsigned n, r, b;
    n = longint'(v) << 30;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic longint cos_of_lat(longint lat);
    longint w, m, c, s;
    bit neg;
    w = wrap_turn(lat);
    m = w < 0 ? -w : w;
    neg = m > QUARTER_TURN;
    if (neg) m = HALF_TURN - m;
    cordic_rotate(to_half_rad(2 * m), c, s);
    return neg ? -c : c;
  endfunction

  function automatic longint sin_of_half(longint d);
    longint c, s;
    cordic_rotate(to_half_rad(wrap_turn(d)), c, s);
    return s;
  endfunction

  function automatic logic [24:0] predict_distance(pair_t p);
    longint s1, s2, a, z;
    longint unsigned d;
    if (!p.present) return '0;
    s1 = sin_of_half(longint'(p.elat) - longint'(p.slat));
    s2 = sin_of_half(longint'(p.elon) - longint'(p.slon));
    a = qmul(s1, s1) + qmul(qmul(cos_of_lat(p.slat), cos_of_lat(p.elat)), qmul(s2, s2));
    a = clip(a, 0, ONE);
    z = cordic_angle(root_q30(ONE - a), root_q30(a));
    d = (radius * longint'(z) + (64'd1 << 28)) >> 29;
    return d > SAT ? 25'(SAT) : 25'(d);
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic add_pair(bit pr, longint sla, longint slo, longint ela, longint elo);
    pair_t p;
    p.present = pr;
    p.slat = 28'(sla);
    p.slon = 29'(slo);
    p.elat = 28'(ela);
    p.elon = 29'(elo);
    pending.push_back(p);
  endtask

  task automatic add_random(int count);
    longint v[4];
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 9) == 0) begin
        v[0] = longint'(signed'(28'($urandom)));
        v[1] = longint'(signed'(29'($urandom)));
        v[2] = longint'(signed'(28'($urandom)));
        v[3] = longint'(signed'(29'($urandom)));
      end else begin
        v[0] = longint'($urandom_range(0, 180000000)) - 90000000;
        v[1] = longint'($urandom_range(0, 360000000)) - 180000000;
        if ($urandom_range(0, 2) == 0) begin
          // nearby points
          v[2] = clip(v[0] + longint'($urandom_range(0, 200000)) - 100000, -90000000, 90000000);
          v[3] = v[1] + longint'($urandom_range(0, 200000)) - 100000;
        end else begin
          v[2] = longint'($urandom_range(0, 180000000)) - 90000000;
          v[3] = longint'($urandom_range(0, 360000000)) - 180000000;
        end
      end
      add_pair($urandom_range(0, 15) != 0, v[0], v[1], v[2], v[3]);
    end
  endtask

  task automatic settle();
    while (pending.size() != 0 || in_tvalid || distances_due.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_radius(logic [23:0] r);
    @(negedge clk);
    cfg_valid <= 1;
    cfg_data <= r;
    do @(posedge clk); while (!cfg_ready);
    radius = 64'(r);
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  always @(posedge clk) begin
    pair_t p;
    in_fire <= in_tvalid && in_tready;
    out_fire <= out_tvalid && out_tready;
    if (rst_n && in_tvalid && in_tready) begin
      p.present = in_tuser;
      p.slat = in_tdata[27:0];
      p.slon = in_tdata[56:28];
      p.elat = in_tdata[84:57];
      p.elon = in_tdata[113:85];
      distances_due.push_back(predict_distance(p));
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (distances_due.size() == 0) begin
        report_mismatch("unexpected beat", out_tdata[24:0], -1);
      end else if (out_tdata[24:0] != distances_due[0]) begin
        report_mismatch("distance_m", out_tdata[24:0], distances_due[0]);
        void'(distances_due.pop_front());
      end else begin
        void'(distances_due.pop_front());
      end
    end
  end

  always @(negedge clk) begin
    pair_t p;
    if (!rst_n || (in_tvalid && !in_fire)) begin
    end else if (gap > 0) begin
      in_tvalid <= 0;
      gap--;
    end else if (pending.size() != 0) begin
      p = pending.pop_front();
      in_tdata <= {6'b0, p.elon, p.elat, p.slon, p.slat};
      in_tuser <= p.present;
      in_tvalid <= 1;
      sent++;
      if (sent % 64 == 0) calm = $urandom_range(0, 3) == 0;
      gap = calm ? 0 : $urandom_range(0, 14);
    end else begin
      in_tvalid <= 0;
    end
  end

  always @(negedge clk) begin
    if (out_fire) stall = calm ? 0 : $urandom_range(0, 14);
    if (stall > 0) begin
      out_tready <= 0;
      stall--;
    end else begin
      out_tready <= 1;
    end
  end

  initial begin
    logic [23:0] radii[5];
    atan_tab[0] = longint'(((PI_Q60 >> 2) + (64'd1 << 29)) >> 30);
    for (int i = 1; i < STAGES; i++) begin
      longint sum;
      sum = 0;
      for (int k = 0; 60 - i * (2 * k + 1) >= 0; k++) begin
        longint t;
        t = longint'((64'd1 << (60 - i * (2 * k + 1))) / longint'(2 * k + 1));
        sum += (k % 2 == 1) ? -t : t;
      end
      atan_tab[i] = longint'((longint'(sum) + (64'd1 << 29)) >> 30);
    end
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    add_pair(0, 45000000, 90000000, -45000000, -90000000);
    add_pair(0, -134217728, -268435456, 134217727, 268435455);
    add_pair(1, 0, 0, 0, 0);
    add_pair(1, 0, 0, 0, 180000000);
    add_pair(1, 90000000, 0, -90000000, 0);
    add_pair(1, -90000000, -180000000, 90000000, 180000000);
    add_pair(1, 0, 170000000, 0, -170000000);
    add_pair(1, 10000000, -179999999, -10000000, 179999999);
    add_pair(1, 100000000, 0, 0, 0);
    add_pair(1, -120000000, 30000000, 80000000, -60000000);
    add_pair(1, -134217728, -268435456, 134217727, 268435455);
    add_pair(1, 134217727, 268435455, -134217728, -268435456);
    add_pair(1, 0, 0, 1, 1);
    add_pair(1, 48856613, 2352222, 40712776, -74005974);
    add_pair(1, 0, -90000000, 0, 90000000);
    add_pair(1, 45000000, 0, 45000000, 0);
    add_random(200);
    settle();

    radii[0] = 24'd1;
    radii[1] = 24'd0;
    radii[2] = 24'hFFFFFF;
    radii[3] = 24'd10000000;
    radii[4] = 24'($urandom_range(1, 10000000));
    foreach (radii[r]) begin
      write_radius(radii[r]);
      add_pair(1, 0, 0, 0, 180000000);
      add_pair(1, 0, 0, 0, 1);
      add_random(160);
      settle();
    end

    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule
